// File: src/motor_thermal_overheat_model_top_assert.svh
// Assertion macros for the motor thermal model checker.
// MTOM_CHECK_NOW: consequent must hold in the same cycle as the trigger.
// MTOM_CHECK_NEXT: consequent must hold one cycle after the trigger.
`ifndef MOTOR_THERMAL_OVERHEAT_MODEL_TOP_ASSERT_SVH
`define MOTOR_THERMAL_OVERHEAT_MODEL_TOP_ASSERT_SVH

`define MTOM_CHECK_NOW(label, clk, rst, trig, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (rhs)) \
      else $error("check failed: label");

`define MTOM_CHECK_NEXT(label, clk, rst, trig, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (rhs)) \
      else $error("check failed: label");

`endif

// File: src/mtom_pkg.sv
// ----------------------------------------------------------------------------
// mtom_pkg
// Shared types and constants of the motor thermal model.
// ----------------------------------------------------------------------------
`default_nettype none

package mtom_pkg;

   localparam int MUL_A_W = 64;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int DIV_N_W = 64;
   localparam int DIV_D_W = 26;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   // constant divisors
   localparam logic [DIV_D_W-1:0] DIV_POWER = 26'd65536000;
   localparam logic [DIV_D_W-1:0] DIV_MILLI = 26'd1000;
   localparam logic [DIV_D_W-1:0] DIV_MICRO = 26'd1000000;

   // register indexes
   localparam logic [2:0] REG_BACKEMF  = 3'd0;
   localparam logic [2:0] REG_COND_WH  = 3'd1;
   localparam logic [2:0] REG_COND_HA  = 3'd2;
   localparam logic [2:0] REG_CINV_W   = 3'd3;
   localparam logic [2:0] REG_CINV_H   = 3'd4;
   localparam logic [2:0] REG_LIMIT    = 3'd5;

   localparam logic [31:0] RST_BACKEMF = 32'd0;
   localparam logic [31:0] RST_COND    = 32'd65536;
   localparam logic [31:0] RST_CINV    = 32'd16777216;
   localparam logic [15:0] RST_LIMIT   = 16'd39680;
   localparam logic signed [47:0] RST_TEMP = 48'sd1006632960;  // 60 C in Q24

   localparam logic [21:0] POWER_MAX = 22'h3FFFFF;
   localparam logic [63:0] PROD_SAT  = 64'h2000_0000_0000_0000;

endpackage

`default_nettype wire

// File: src/mtom_mul_serial.sv
// ----------------------------------------------------------------------------
// mtom_mul_serial
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mtom_mul_serial (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mtom_pkg::mul_req_type         req,
   output logic                               done,
   output logic [mtom_pkg::MUL_P_W-1:0]       product
);

   localparam int CNT_W = $clog2(mtom_pkg::MUL_B_W);

   logic [mtom_pkg::MUL_A_W-1:0] a_ff;
   logic [mtom_pkg::MUL_P_W-1:0] p_ff, p_in;
   logic [CNT_W-1:0]             cnt_ff;
   logic                         run_ff, done_ff;
   logic [mtom_pkg::MUL_A_W:0]   sum;

   // add multiplicand on low bit, shift product right
   always_comb begin
      sum  = {1'b0, p_ff[mtom_pkg::MUL_P_W-1:mtom_pkg::MUL_B_W]} +
             (p_ff[0] ? {1'b0, a_ff} : {(mtom_pkg::MUL_A_W+1){1'b0}});
      p_in = {sum, p_ff[mtom_pkg::MUL_B_W-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(mtom_pkg::MUL_B_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         a_ff <= req.a;
         p_ff <= {{mtom_pkg::MUL_A_W{1'b0}}, req.b};
      end else if (run_ff) begin
         p_ff <= p_in;
      end
   end

   assign done    = done_ff;
   assign product = p_ff;

endmodule

`default_nettype wire

// File: src/mtom_div_serial.sv
// ----------------------------------------------------------------------------
// mtom_div_serial
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mtom_div_serial (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mtom_pkg::div_req_type         req,
   output logic                               done,
   output logic [mtom_pkg::DIV_N_W-1:0]       quotient
);

   localparam int NW    = mtom_pkg::DIV_N_W;
   localparam int DW    = mtom_pkg::DIV_D_W;
   localparam int CNT_W = $clog2(NW);

   logic [NW-1:0]    q_ff, q_in;
   logic [DW-1:0]    rem_ff, rem_in, d_ff;
   logic [DW:0]      trial, diff;
   logic             ge;
   logic [CNT_W-1:0] cnt_ff;
   logic             run_ff, done_ff;

   // one trial subtraction per cycle
   always_comb begin
      trial  = {rem_ff, q_ff[NW-1]};
      diff   = trial - {1'b0, d_ff};
      ge     = trial >= {1'b0, d_ff};
      rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
      q_in   = {q_ff[NW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NW - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         q_ff   <= req.dividend;
         rem_ff <= '0;
         d_ff   <= req.divisor;
      end else if (run_ff) begin
         q_ff   <= q_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

// File: src/motor_thermal_overheat_model_top.sv
// ----------------------------------------------------------------------------
// motor_thermal_overheat_model_top
// Two-node (winding, housing) motor thermal model with overheat flag.
// ----------------------------------------------------------------------------
// One motor sample is handled at a time. A sample update runs nine products
// through the bit-serial multiplier and four quotients through the
// bit-serial divider, then loads the result and returns to idle. When
// voltage and current give no heating, the heating product and its
// quotient are skipped. A clear command goes straight to the final step.
// The result sits in an output register, so the next sample is taken
// while the previous result waits for its transfer; a new result waits in
// the final step until the output register is free.
`default_nettype none

module motor_thermal_overheat_model_top (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // pwm_ratio, supply_mv, velocity_mrad, current_ma, ambient_temp,
   // duration_us, zero pad
   input  wire logic [111:0] req_tdata,
   // cmd
   input  wire logic [0:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // winding_temp, housing_temp, heat_power_mw, zero pad
   output logic [55:0]       rsp_tdata,
   // overheat, hot_warning
   output logic [1:0]        rsp_tuser,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_wdata
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PWM   = 4'd1;
   localparam logic [3:0] S_EMF   = 4'd2;
   localparam logic [3:0] S_PMUL  = 4'd3;
   localparam logic [3:0] S_PDIV  = 4'd4;
   localparam logic [3:0] S_HEAT  = 4'd5;
   localparam logic [3:0] S_FWH   = 4'd6;
   localparam logic [3:0] S_FHA   = 4'd7;
   localparam logic [3:0] S_WRATE = 4'd8;
   localparam logic [3:0] S_WDT   = 4'd9;
   localparam logic [3:0] S_WDIV  = 4'd10;
   localparam logic [3:0] S_HRATE = 4'd11;
   localparam logic [3:0] S_HDT   = 4'd12;
   localparam logic [3:0] S_HDIV  = 4'd13;
   localparam logic [3:0] S_FIN   = 4'd14;

   localparam logic signed [63:0] V_HI = 64'sh0001_0000_0000_0000;
   localparam logic signed [63:0] V_LO = -64'sh0001_0000_0000_0000;
   localparam logic signed [63:0] T_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] T_LO = -64'sh0000_8000_0000_0000;

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic signed [47:0] clamp48(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = (v < T_LO) ? T_LO : ((v > T_HI) ? T_HI : v);
      return r[47:0];
   endfunction

   function automatic logic [15:0] to_q88(input logic signed [47:0] t);
      logic signed [47:0] adj;
      logic signed [31:0] q;
      adj = t[47] ? (t + 48'sd65535) : t;
      q   = adj[47:16];
      if (q > 32'sd32767)       return 16'h7FFF;
      else if (q < -32'sd32768) return 16'h8000;
      else                      return q[15:0];
   endfunction

   function automatic logic signed [63:0] sx48(input logic signed [47:0] t);
      return {{16{t[47]}}, t};
   endfunction

   // configuration
   logic [31:0] gain_ff, cwh_ff, cha_ff, cinvw_ff, cinvh_ff;
   logic [15:0] limit_ff;

   // captured sample
   logic               cmd_ff;
   logic signed [15:0] pwm_ff, cur_ff, amb_ff;
   logic [15:0]        sup_ff;
   logic signed [23:0] vel_ff;
   logic [19:0]        dt_ff;

   // sequencer and intermediates
   logic [3:0]         state_ff;
   logic               busy_ff, neg_ff;
   logic signed [63:0] p1_ff, volt_ff, pheat_ff, fwh_ff, fha_ff, rate_ff;
   logic [63:0]        mag_ff;
   logic [21:0]        power_ff;
   logic signed [47:0] tw_ff, th_ff;
   logic               flag_ff;

   // output register
   logic        rsp_tvalid_ff;
   logic [55:0] rsp_tdata_ff;
   logic [1:0]  rsp_tuser_ff;

   mtom_pkg::mul_req_type         mul_req;
   mtom_pkg::div_req_type         div_req;
   logic                          mul_done, div_done;
   logic [mtom_pkg::MUL_P_W-1:0]  product;
   logic [mtom_pkg::DIV_N_W-1:0]  quotient;

   mtom_mul_serial u_mul (
      .clock   (clock),
      .reset   (reset),
      .req     (mul_req),
      .done    (mul_done),
      .product (product)
   );

   mtom_div_serial u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (quotient)
   );

   // operand selection per step
   logic               is_mul, is_div, skip, launch, unit_done, op_neg, pcond;
   logic [63:0]        op_a, op_div;
   logic [31:0]        op_b;
   logic [25:0]        op_d;
   logic [6:0]         shamt;
   logic signed [63:0] diff_wh, diff_ha, flow_w, flow_h, amb_q24;
   logic [95:0]        shifted;
   logic [63:0]        mag_sat;
   logic signed [63:0] sres, vnext, change, qsigned;

   always_comb begin
      amb_q24 = {{32{amb_ff[15]}}, amb_ff, 16'd0};
      diff_wh = sx48(tw_ff) - sx48(th_ff);
      diff_ha = sx48(th_ff) - amb_q24;
      flow_w  = pheat_ff - fwh_ff;
      flow_h  = fwh_ff - fha_ff;
      pcond   = (volt_ff > 64'sd0 && cur_ff > 16'sd0) ||
                (volt_ff < 64'sd0 && cur_ff < 16'sd0);

      is_mul = 1'b0;
      is_div = 1'b0;
      op_a   = '0;
      op_b   = '0;
      op_neg = 1'b0;
      op_div = '0;
      op_d   = mtom_pkg::DIV_MICRO;
      shamt  = 7'd0;
      case (state_ff)
         S_PWM: begin
            is_mul = 1'b1;
            op_a   = 64'(mag64(64'(pwm_ff)));
            op_b   = {16'd0, sup_ff};
            op_neg = pwm_ff[15];
         end
         S_EMF: begin
            is_mul = 1'b1;
            op_a   = mag64(64'(vel_ff));
            op_b   = gain_ff;
            op_neg = vel_ff[23];
         end
         S_PMUL: begin
            is_mul = 1'b1;
            op_a   = mag64(volt_ff);
            op_b   = 32'(mag64(64'(cur_ff)));
         end
         S_PDIV: begin
            is_div = 1'b1;
            op_div = mag_ff;
            op_d   = mtom_pkg::DIV_POWER;
         end
         S_HEAT: begin
            is_div = 1'b1;
            op_div = {18'd0, power_ff, 24'd0};
            op_d   = mtom_pkg::DIV_MILLI;
         end
         S_FWH: begin
            is_mul = 1'b1;
            op_a   = mag64(diff_wh);
            op_b   = cwh_ff;
            op_neg = diff_wh[63];
            shamt  = 7'd16;
         end
         S_FHA: begin
            is_mul = 1'b1;
            op_a   = mag64(diff_ha);
            op_b   = cha_ff;
            op_neg = diff_ha[63];
            shamt  = 7'd16;
         end
         S_WRATE: begin
            is_mul = 1'b1;
            op_a   = mag64(flow_w);
            op_b   = cinvw_ff;
            op_neg = flow_w[63];
            shamt  = 7'd24;
         end
         S_HRATE: begin
            is_mul = 1'b1;
            op_a   = mag64(flow_h);
            op_b   = cinvh_ff;
            op_neg = flow_h[63];
            shamt  = 7'd24;
         end
         S_WDT, S_HDT: begin
            is_mul = 1'b1;
            op_a   = mag64(rate_ff);
            op_b   = {12'd0, dt_ff};
            op_neg = rate_ff[63];
         end
         S_WDIV, S_HDIV: begin
            is_div = 1'b1;
            op_div = mag_ff;
         end
         default: begin
            is_mul = 1'b0;
         end
      endcase

      skip      = (state_ff == S_PMUL) && !pcond;
      launch    = (is_mul || is_div) && !busy_ff && !skip;
      unit_done = (is_mul && mul_done) || (is_div && div_done);

      mul_req.start    = launch && is_mul;
      mul_req.a        = op_a;
      mul_req.b        = op_b;
      div_req.start    = launch && is_div;
      div_req.dividend = op_div;
      div_req.divisor  = op_d;

      // shift, saturate magnitude, apply sign
      shifted = product >> shamt;
      mag_sat = (shifted > {32'd0, mtom_pkg::PROD_SAT}) ? mtom_pkg::PROD_SAT
                                                        : shifted[63:0];
      sres    = neg_ff ? -$signed(mag_sat) : $signed(mag_sat);
      vnext   = (p1_ff <<< 1) - sres;
      qsigned = $signed(quotient);
      change  = neg_ff ? -qsigned : qsigned;
   end

   // result flags
   logic signed [52:0] tw10, lim9, lim53;
   logic signed [63:0] lim64;
   logic               over_now, hot, out_free, out_load;

   always_comb begin
      lim53    = {5'd0, limit_ff, 32'd0} >>> 16;
      lim64    = {16'd0, limit_ff, 32'd0} >>> 16;
      tw10     = ({{5{tw_ff[47]}}, tw_ff} <<< 3) + ({{5{tw_ff[47]}}, tw_ff} <<< 1);
      lim9     = (lim53 <<< 3) + lim53;
      hot      = tw10 > lim9;
      over_now = flag_ff || (!cmd_ff && (sx48(tw_ff) > lim64));
      out_free = !rsp_tvalid_ff || rsp_tready;
      out_load = (state_ff == S_FIN) && out_free;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= mtom_pkg::RST_BACKEMF;
         cwh_ff   <= mtom_pkg::RST_COND;
         cha_ff   <= mtom_pkg::RST_COND;
         cinvw_ff <= mtom_pkg::RST_CINV;
         cinvh_ff <= mtom_pkg::RST_CINV;
         limit_ff <= mtom_pkg::RST_LIMIT;
      end else if (csr_we) begin
         case (csr_index)
            mtom_pkg::REG_BACKEMF: gain_ff  <= csr_wdata;
            mtom_pkg::REG_COND_WH: cwh_ff   <= csr_wdata;
            mtom_pkg::REG_COND_HA: cha_ff   <= csr_wdata;
            mtom_pkg::REG_CINV_W:  cinvw_ff <= csr_wdata;
            mtom_pkg::REG_CINV_H:  cinvh_ff <= csr_wdata;
            mtom_pkg::REG_LIMIT:   limit_ff <= csr_wdata[15:0];
            default:               gain_ff  <= gain_ff;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         busy_ff       <= 1'b0;
         tw_ff         <= mtom_pkg::RST_TEMP;
         th_ff         <= mtom_pkg::RST_TEMP;
         flag_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (out_load)        rsp_tvalid_ff <= 1'b1;
         else if (rsp_tready) rsp_tvalid_ff <= 1'b0;
         if (launch) begin
            busy_ff <= 1'b1;
            neg_ff  <= is_mul ? op_neg : neg_ff;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  cmd_ff   <= req_tuser[0];
                  pwm_ff   <= req_tdata[15:0];
                  sup_ff   <= req_tdata[31:16];
                  vel_ff   <= req_tdata[55:32];
                  cur_ff   <= req_tdata[71:56];
                  amb_ff   <= req_tdata[87:72];
                  dt_ff    <= req_tdata[107:88];
                  power_ff <= '0;
                  if (req_tuser[0]) begin
                     flag_ff  <= 1'b0;
                     state_ff <= S_FIN;
                  end else begin
                     state_ff <= S_PWM;
                  end
               end
            end
            S_FIN: begin
               if (out_free) begin
                  rsp_tdata_ff  <= {2'd0, power_ff, to_q88(th_ff), to_q88(tw_ff)};
                  rsp_tuser_ff  <= {hot, over_now};
                  flag_ff       <= over_now;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               if (skip) begin
                  power_ff <= '0;
                  state_ff <= S_HEAT;
               end else if (busy_ff && unit_done) begin
                  busy_ff <= 1'b0;
                  case (state_ff)
                     S_PWM: begin
                        p1_ff    <= sres;
                        state_ff <= S_EMF;
                     end
                     S_EMF: begin
                        volt_ff  <= (vnext > V_HI) ? V_HI : ((vnext < V_LO) ? V_LO : vnext);
                        state_ff <= S_PMUL;
                     end
                     S_PMUL: begin
                        mag_ff   <= product[63:0];
                        state_ff <= S_PDIV;
                     end
                     S_PDIV: begin
                        power_ff <= (quotient > 64'(mtom_pkg::POWER_MAX)) ?
                                    mtom_pkg::POWER_MAX : quotient[21:0];
                        state_ff <= S_HEAT;
                     end
                     S_HEAT: begin
                        pheat_ff <= qsigned;
                        state_ff <= S_FWH;
                     end
                     S_FWH: begin
                        fwh_ff   <= sres;
                        state_ff <= S_FHA;
                     end
                     S_FHA: begin
                        fha_ff   <= sres;
                        state_ff <= S_WRATE;
                     end
                     S_WRATE: begin
                        rate_ff  <= sres;
                        state_ff <= S_WDT;
                     end
                     S_WDT: begin
                        mag_ff   <= mag_sat;
                        state_ff <= S_WDIV;
                     end
                     S_WDIV: begin
                        tw_ff    <= clamp48(sx48(tw_ff) + change);
                        state_ff <= S_HRATE;
                     end
                     S_HRATE: begin
                        rate_ff  <= sres;
                        state_ff <= S_HDT;
                     end
                     S_HDT: begin
                        mag_ff   <= mag_sat;
                        state_ff <= S_HDIV;
                     end
                     S_HDIV: begin
                        th_ff    <= clamp48(sx48(th_ff) + change);
                        state_ff <= S_FIN;
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

`default_nettype wire

// File: src/mtom_checker.sv
// ----------------------------------------------------------------------------
// mtom_checker
// Port-level checks of the motor thermal model, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "motor_thermal_overheat_model_top_assert.svh"

module mtom_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [55:0] rsp_tdata
);

   // a stalled result holds
   `MTOM_CHECK_NEXT(rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // a sample transfer makes the block busy
   `MTOM_CHECK_NEXT(busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)

   // a new result always comes with the sequencer back at idle
   `MTOM_CHECK_NOW(idle_on_result, clock, reset, $rose(rsp_tvalid), req_tready)

endmodule

bind motor_thermal_overheat_model_top mtom_checker u_mtom_checker (.*);

`default_nettype wire
